// File: rtl/core/ise_pkg.sv
// ----------------------------------------------------------------------------
// ise_pkg
// Shared types for the insertion sort engine: controller states and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package ise_pkg;

	localparam int unsigned KEY_BITS = 32;

	typedef enum logic [1:0] {
		ST_LOAD  = 2'b01,
		ST_DRAIN = 2'b10
	} ise_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic insert;   // place the accepted input item into the cell row unless it is full
		logic shift;    // the head item was taken, move the row down by one
	} ise_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic last_one; // exactly one item left in the row
	} ise_status_t;

endpackage

// File: rtl/core/ise_ctrl.sv
// ----------------------------------------------------------------------------
// ise_ctrl
// Controller of the insertion sort engine. Loads items until the request
// marked last, then drains the sorted row until its last item is taken.
// ----------------------------------------------------------------------------
module ise_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tlast,
	output logic                  s_tready,
	input  logic                  m_tready,
	output logic                  m_tvalid,
	input  ise_pkg::ise_status_t  status,
	output ise_pkg::ise_cmd_t     cmd
);
	import ise_pkg::*;

	ise_state_t state_q;
	ise_state_t state_d;

	assign s_tready   = (state_q == ST_LOAD);
	assign m_tvalid   = (state_q == ST_DRAIN);
	assign cmd.insert = s_tvalid && s_tready;
	assign cmd.shift  = m_tvalid && m_tready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (cmd.insert && s_tlast) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (cmd.shift && status.last_one) begin
					state_d = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: rtl/core/ise_datapath.sv
// ----------------------------------------------------------------------------
// ise_datapath
// Row of compare-and-shift cells holding the sorted items, with the fill
// count, the overflow flag and the direction register.
// ----------------------------------------------------------------------------
module ise_datapath #(
	parameter int unsigned CAPACITY = 32,
	parameter int unsigned TAG_BITS = 16,
	parameter int unsigned DATA_W   = ((32 + TAG_BITS + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic                  cfg_wr_data,
	input  logic [DATA_W-1:0]     s_tdata,
	output logic [DATA_W-1:0]     m_tdata,
	output logic                  m_tlast,
	output logic                  m_tuser,
	input  ise_pkg::ise_cmd_t     cmd,
	output ise_pkg::ise_status_t  status
);
	import ise_pkg::*;

	localparam int unsigned FILL_W = $clog2(CAPACITY + 1);

	logic signed [KEY_BITS-1:0] key_q [CAPACITY];
	logic        [TAG_BITS-1:0] tag_q [CAPACITY];
	logic        [FILL_W-1:0]   fill_q;
	logic                       dropped_q;
	logic                       descending_q;

	logic signed [KEY_BITS-1:0] new_key;
	logic        [TAG_BITS-1:0] new_tag;
	logic                       full;
	logic                       do_insert;
	logic        [CAPACITY-1:0] ahead;
	logic        [CAPACITY:0]   pass;

	assign new_key   = $signed(s_tdata[KEY_BITS-1:0]);
	assign new_tag   = s_tdata[KEY_BITS +: TAG_BITS];
	assign full      = (fill_q == FILL_W'(CAPACITY));
	assign do_insert = cmd.insert && !full;

	// pass[i] is set while every occupied cell below i precedes the new key,
	// so the insertion point is the lowest cell where pass holds but ahead
	// does not.
	assign pass[0] = 1'b1;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		assign ahead[i] = (FILL_W'(i) < fill_q) &&
			(descending_q ? (key_q[i] > new_key) : (key_q[i] < new_key));
		assign pass[i+1] = pass[i] && ahead[i];

		always_ff @(posedge clk) begin
			if (do_insert) begin
				if (pass[i] && !ahead[i]) begin
					key_q[i] <= new_key;
					tag_q[i] <= new_tag;
				end else if (!pass[i]) begin
					if (i > 0) begin
						key_q[i] <= key_q[(i > 0) ? i - 1 : 0];
						tag_q[i] <= tag_q[(i > 0) ? i - 1 : 0];
					end
				end
			end else if (cmd.shift) begin
				if (i < CAPACITY - 1) begin
					key_q[i] <= key_q[(i < CAPACITY - 1) ? i + 1 : i];
					tag_q[i] <= tag_q[(i < CAPACITY - 1) ? i + 1 : i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q       <= '0;
			dropped_q    <= 1'b0;
			descending_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				descending_q <= cfg_wr_data;
			end
			if (cmd.insert) begin
				if (full) begin
					dropped_q <= 1'b1;
				end else begin
					fill_q <= fill_q + FILL_W'(1);
				end
			end else if (cmd.shift) begin
				fill_q <= fill_q - FILL_W'(1);
				if (status.last_one) begin
					dropped_q <= 1'b0;
				end
			end
		end
	end

	assign status.last_one = (fill_q == FILL_W'(1));

	assign m_tdata = DATA_W'({tag_q[0], key_q[0]});
	assign m_tlast = status.last_one;
	assign m_tuser = dropped_q;

endmodule

// File: rtl/core/insertion_sort_engine.sv
// ----------------------------------------------------------------------------
// insertion_sort_engine
// Sorts a set of keyed items by insertion and streams them out in order.
// ----------------------------------------------------------------------------
// Each input request is taken as it arrives: a row of CAPACITY compare-and-shift
// cells finds the insertion point and opens the gap in the same clock, so
// s_tready stays high while loading. A new item lands ahead of stored items
// with an equal key; cfg_wr_data picks descending (1) or ascending (0) order
// and applies to later insertions. The request with s_tlast starts the
// drain: s_tready drops and the row is shifted out one item per cycle from
// the head cell while m_tready is high, with m_tlast on the last one. Items
// that find the row full are dropped and m_tuser is 1 on every output of
// that set. The cycle after the last output is taken, loading resumes.
module insertion_sort_engine #(
	parameter int unsigned CAPACITY = 32,
	parameter int unsigned TAG_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wr_en,
	input  logic cfg_wr_data,   // descending
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [((32 + TAG_BITS + 7) / 8) * 8 - 1:0] s_tdata,  // sort_key, tag, zero pad
	input  logic s_tlast,       // final_item
	output logic m_tvalid,
	input  logic m_tready,
	output logic [((32 + TAG_BITS + 7) / 8) * 8 - 1:0] m_tdata,  // out_key, out_tag, zero pad
	output logic m_tlast,       // run_end
	output logic m_tuser        // overflow
);
	import ise_pkg::*;

	localparam int unsigned DATA_W = ((KEY_BITS + TAG_BITS + 7) / 8) * 8;

	ise_cmd_t    cmd;
	ise_status_t status;

	ise_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.status   (status),
		.cmd      (cmd)
	);

	ise_datapath #(
		.CAPACITY (CAPACITY),
		.TAG_BITS (TAG_BITS),
		.DATA_W   (DATA_W)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tdata     (s_tdata),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast),
		.m_tuser     (m_tuser),
		.cmd         (cmd),
		.status      (status)
	);

endmodule

// File: rtl/core/ise_checker.sv
// ----------------------------------------------------------------------------
// ise_checker
// Port-level checks for the insertion sort engine, bound to the top level.
// ----------------------------------------------------------------------------
module ise_checker #(
	parameter int unsigned TAG_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic s_tlast,
	input logic m_tvalid,
	input logic m_tready,
	input logic [((32 + TAG_BITS + 7) / 8) * 8 - 1:0] m_tdata,
	input logic m_tlast,
	input logic m_tuser
);

	// Loading and draining never overlap.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(m_tvalid && s_tready))
		else $error("load and drain active together");

	// The last input request starts the drain in the next cycle.
	a_drain_start: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |=> m_tvalid)
		else $error("drain did not start after last input");

	// Taking the last output returns to loading.
	a_drain_end: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> (!m_tvalid && s_tready))
		else $error("drain did not end after last output");

	// The overflow flag is the same on every output of a set.
	a_flag_steady: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=> (m_tuser == $past(m_tuser)))
		else $error("overflow flag changed within a set");

	// A stalled output holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
		else $error("stalled output changed");

endmodule

bind insertion_sort_engine ise_checker #(.TAG_BITS(TAG_BITS)) u_ise_checker (.*);
